@@ src/psar_pkg.sv @@
// ----------------------------------------------------------------------------
// psar_pkg
// Shared types, trend codes and register defaults of the parabolic
// stop-and-reverse indicator.
// ----------------------------------------------------------------------------
package psar_pkg;

  localparam int unsigned PRICE_W   = 32;
  localparam int unsigned FACTOR_W  = 16;
  localparam int unsigned INDEX_W   = 16;
  localparam int unsigned TREND_W   = 3;
  localparam int unsigned CFG_IDX_W = 8;

  // trend codes
  localparam logic [TREND_W-1:0] TREND_NONE     = 3'd0;
  localparam logic [TREND_W-1:0] TREND_LONG     = 3'd1;
  localparam logic [TREND_W-1:0] TREND_SHORT    = 3'd2;
  localparam logic [TREND_W-1:0] TREND_TO_SHORT = 3'd3;
  localparam logic [TREND_W-1:0] TREND_TO_LONG  = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_INDEX = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_STEP  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_MAX   = 8'd2;

  localparam logic [INDEX_W-1:0]  START_INDEX_RST = 16'd10;
  localparam logic [FACTOR_W-1:0] ACCEL_STEP_RST  = 16'd1311;
  localparam logic [FACTOR_W-1:0] ACCEL_MAX_RST   = 16'd13107;

  typedef logic signed [PRICE_W-1:0] price_t;
  typedef logic [FACTOR_W-1:0]       factor_t;

  typedef struct packed {
    logic [INDEX_W-1:0] start_index;
    factor_t            accel_step;
    factor_t            accel_max;
  } cfg_t;

  typedef struct packed {
    logic [TREND_W-1:0] trend;
    price_t             stop;
    factor_t            factor;
  } sar_state_t;

  typedef struct packed {
    logic [INDEX_W-1:0] bar_index;
    price_t             bar_high;
    price_t             bar_low;
    price_t             window_highest;
    price_t             window_lowest;
  } bar_t;

endpackage

@@ src/psar_if.sv @@
// ----------------------------------------------------------------------------
// psar channel interfaces
// Valid/ready channels for price bars, indicator results and register writes.
// ----------------------------------------------------------------------------
interface psar_bar_if import psar_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] bar_index;
  price_t             bar_high;
  price_t             bar_low;
  price_t             window_highest;
  price_t             window_lowest;

  modport source (output valid, bar_index, bar_high, bar_low, window_highest,
                  window_lowest, input ready);
  modport sink   (input valid, bar_index, bar_high, bar_low, window_highest,
                  window_lowest, output ready);
endinterface

interface psar_res_if import psar_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TREND_W-1:0] trend_state;
  price_t             stop_value;
  factor_t            accel_factor;

  modport source (output valid, trend_state, stop_value, accel_factor, input ready);
  modport sink   (input valid, trend_state, stop_value, accel_factor, output ready);
endinterface

interface psar_cfg_if import psar_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [FACTOR_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ src/psar_cfg.sv @@
// ----------------------------------------------------------------------------
// psar_cfg
// Configuration register file: start index, acceleration step and maximum.
// ----------------------------------------------------------------------------
module psar_cfg import psar_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  psar_cfg_if.sink     cfg_i,
  output cfg_t         cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_START_INDEX: cfg_d.start_index = cfg_i.data;
        CFG_ACCEL_STEP:  cfg_d.accel_step  = cfg_i.data;
        CFG_ACCEL_MAX:   cfg_d.accel_max   = cfg_i.data;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_index <= START_INDEX_RST;
      cfg_q.accel_step  <= ACCEL_STEP_RST;
      cfg_q.accel_max   <= ACCEL_MAX_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ src/psar_step.sv @@
// ----------------------------------------------------------------------------
// psar_step
// Next-state logic for one bar: seeding, factor growth, stop move with
// round-to-nearest and saturation, trend exit and reversal steps.
// ----------------------------------------------------------------------------
module psar_step import psar_pkg::*; (
  input  cfg_t       cfg_i,
  input  sar_state_t cur_i,
  input  bar_t       bar_i,
  output sar_state_t nxt_o
);

  logic [FACTOR_W:0]         grow_sum;
  factor_t                   grown;
  logic                      new_ext;
  factor_t                   move_factor;
  price_t                    target;
  logic signed [PRICE_W:0]   diff;
  logic signed [FACTOR_W:0]  factor_s;
  logic signed [49:0]        prod;
  logic signed [49:0]        prod_rnd;
  logic signed [33:0]        delta;
  logic signed [34:0]        sum;
  price_t                    moved;
  logic                      is_short;

  assign is_short = (cur_i.trend == TREND_SHORT);

  assign grow_sum = {1'b0, cur_i.factor} + {1'b0, cfg_i.accel_step};
  assign grown    = (grow_sum > {1'b0, cfg_i.accel_max}) ? cfg_i.accel_max
                                                         : grow_sum[FACTOR_W-1:0];
  assign new_ext  = is_short ? (bar_i.bar_low < bar_i.window_lowest)
                             : (bar_i.bar_high > bar_i.window_highest);
  assign move_factor = new_ext ? grown : cur_i.factor;

  assign target   = is_short ? bar_i.window_lowest : bar_i.window_highest;
  assign diff     = {target[PRICE_W-1], target} - {cur_i.stop[PRICE_W-1], cur_i.stop};
  assign factor_s = {1'b0, move_factor};
  assign prod     = 50'(diff) * 50'(factor_s);
  assign prod_rnd = prod + 50'sd32768;
  assign delta    = prod_rnd[49:16];
  assign sum      = {{3{cur_i.stop[PRICE_W-1]}}, cur_i.stop} + {delta[33], delta};

  always_comb begin
    if (sum[34:31] == 4'b0000 || sum[34:31] == 4'b1111) begin
      moved = sum[31:0];
    end else if (sum[34]) begin
      moved = 32'sh8000_0000;
    end else begin
      moved = 32'sh7fff_ffff;
    end
  end

  always_comb begin
    nxt_o = cur_i;
    if (bar_i.bar_index == cfg_i.start_index) begin
      nxt_o.factor = cfg_i.accel_step;
      nxt_o.trend  = TREND_NONE;
      if (bar_i.window_highest > bar_i.bar_high) begin
        nxt_o.stop  = bar_i.window_highest;
        nxt_o.trend = TREND_SHORT;
      end else if (bar_i.window_lowest < bar_i.bar_low) begin
        nxt_o.stop  = bar_i.window_lowest;
        nxt_o.trend = TREND_LONG;
      end
    end else if (bar_i.bar_index > cfg_i.start_index) begin
      unique case (cur_i.trend)
        TREND_LONG: begin
          nxt_o.factor = move_factor;
          nxt_o.stop   = moved;
          nxt_o.trend  = (moved < bar_i.bar_low) ? TREND_LONG : TREND_TO_SHORT;
        end
        TREND_SHORT: begin
          nxt_o.factor = move_factor;
          nxt_o.stop   = moved;
          nxt_o.trend  = (moved > bar_i.bar_high) ? TREND_SHORT : TREND_TO_LONG;
        end
        TREND_TO_SHORT: begin
          nxt_o.factor = cfg_i.accel_step;
          nxt_o.stop   = bar_i.window_highest;
          nxt_o.trend  = (bar_i.window_highest > bar_i.bar_high) ? TREND_SHORT
                                                                 : TREND_TO_LONG;
        end
        TREND_TO_LONG: begin
          nxt_o.factor = cfg_i.accel_step;
          nxt_o.stop   = bar_i.window_lowest;
          nxt_o.trend  = (bar_i.window_lowest < bar_i.bar_low) ? TREND_LONG
                                                               : TREND_TO_SHORT;
        end
        default: nxt_o = cur_i;
      endcase
    end
  end

endmodule

@@ src/parabolic_stop_and_reverse.sv @@
// ----------------------------------------------------------------------------
// parabolic_stop_and_reverse
// Bar to result: the bar goes through the input register, then the state register.
// Throughput: one bar per cycle unless a result not taken stalls the input register;
// the multiply-add stop update is combinational and closes the state loop.
// Reset: trend, stop and factor clear to zero, registers take their defaults.
// ----------------------------------------------------------------------------
module parabolic_stop_and_reverse import psar_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  psar_bar_if.sink   in_i,
  psar_res_if.source out_o,
  psar_cfg_if.sink   cfg_i
);

  cfg_t       cfg;
  bar_t       bar_q;
  logic       bar_vld_q;
  logic       out_vld_q;
  sar_state_t st_q, st_d;
  logic       advance;
  logic       in_ready;

  psar_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_i,
    .cfg_o (cfg)
  );

  psar_step u_step (
    .cfg_i (cfg),
    .cur_i (st_q),
    .bar_i (bar_q),
    .nxt_o (st_d)
  );

  assign advance     = bar_vld_q && (!out_vld_q || out_o.ready);
  assign in_ready    = !bar_vld_q || advance;
  assign in_i.ready  = in_ready;

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_ready) begin
      bar_q.bar_index      <= in_i.bar_index;
      bar_q.bar_high       <= in_i.bar_high;
      bar_q.bar_low        <= in_i.bar_low;
      bar_q.window_highest <= in_i.window_highest;
      bar_q.window_lowest  <= in_i.window_lowest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bar_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
      st_q      <= '0;
    end else begin
      if (in_ready) begin
        bar_vld_q <= in_i.valid;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        st_q      <= st_d;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.trend_state  = st_q.trend;
  assign out_o.stop_value   = st_q.stop;
  assign out_o.accel_factor = st_q.factor;

  a_adv_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_vld_q)
    else $error("advanced bar produced no result");

  a_full_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bar_vld_q && out_vld_q && !out_o.ready) |-> !in_ready)
    else $error("input taken while both stages are full");

  a_held_bar_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bar_vld_q && !advance) |=> (bar_vld_q && $stable(bar_q)))
    else $error("pending bar lost or changed");

  a_reversal_resets_factor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && bar_q.bar_index > cfg.start_index &&
     (st_q.trend == TREND_TO_SHORT || st_q.trend == TREND_TO_LONG))
    |=> (st_q.factor == $past(cfg.accel_step)))
    else $error("reversal step did not restart the factor");

endmodule

@@ tb/parabolic_stop_and_reverse_tb.sv @@
// ----------------------------------------------------------------------------
// parabolic_stop_and_reverse_tb
// Self-checking bench for the stop-and-reverse indicator. A directed table
// walks seeding, both trends, both reversal steps and the price extremes,
// then random bar series run under several register settings. Results are checked
// in order against pinned rows or an in-bench predictor of trend, stop and factor,
// with random idling on both channels, a long receiver hold-off and drains.
// ----------------------------------------------------------------------------
module parabolic_stop_and_reverse_tb import psar_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int Q1    = 65536;
  localparam int P_MAX = 2147483647;
  localparam int P_MIN = -2147483647 - 1;

  typedef enum {PH_PLAIN, PH_BACKPRESSURE, PH_CALM, PH_DRAIN_MIDWAY} phase_kind_e;

  typedef struct {
    bit         pinned;
    sar_state_t want;
  } bar_note_t;

  typedef struct {
    bar_t       stim;
    bit         pinned;
    sar_state_t want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  psar_bar_if bar_ch ();
  psar_res_if res_ch ();
  psar_cfg_if cfg_ch ();

  parabolic_stop_and_reverse uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (bar_ch),
    .out_o (res_ch),
    .cfg_i (cfg_ch)
  );

  cfg_t       model_cfg   = '{START_INDEX_RST, ACCEL_STEP_RST, ACCEL_MAX_RST};
  sar_state_t model_state = '0;

  sar_state_t pending_results[$];
  bar_note_t  bar_notes[$];
  dir_row_t   directed_rows[$];
  int         fail_count = 0;

  bit calm     = 1'b0;
  int hold_req = 0;

  // random bar series state
  longint walk_mid;
  int unsigned walk_vol;
  int unsigned window_len;
  longint hist_hi[$];
  longint hist_lo[$];
  int unsigned bar_pos;
  int unsigned phase_start;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // predictor

  function automatic price_t clamp_price(input longint v);
    if (v > longint'(P_MAX)) return price_t'(P_MAX);
    if (v < longint'(P_MIN)) return price_t'(P_MIN);
    return price_t'(v);
  endfunction

  function automatic price_t trail_stop(input price_t stop, input price_t target,
                                        input factor_t f);
    longint gap;
    longint prod;
    gap  = longint'(target) - longint'(stop);
    prod = gap * longint'(f);
    return clamp_price(longint'(stop) + ((prod + 32768) >>> 16));
  endfunction

  function automatic factor_t boost_factor(input factor_t f, input cfg_t c);
    int unsigned g;
    g = int'(f) + int'(c.accel_step);
    return (g > int'(c.accel_max)) ? c.accel_max : factor_t'(g);
  endfunction

  function automatic sar_state_t advance_sar(input sar_state_t s, input bar_t b,
                                             input cfg_t c);
    sar_state_t n;
    price_t hi, lo, hh, ll;
    n  = s;
    hi = b.bar_high;
    lo = b.bar_low;
    hh = b.window_highest;
    ll = b.window_lowest;
    if (b.bar_index == c.start_index) begin
      n.factor = c.accel_step;
      n.trend  = TREND_NONE;
      if (ll < lo) begin
        n.stop  = ll;
        n.trend = TREND_LONG;
      end
      if (hh > hi) begin
        n.stop  = hh;
        n.trend = TREND_SHORT;
      end
    end else if (b.bar_index > c.start_index) begin
      case (s.trend)
        TREND_LONG: begin
          if (hi > hh) n.factor = boost_factor(s.factor, c);
          n.stop  = trail_stop(s.stop, hh, n.factor);
          n.trend = (n.stop < lo) ? TREND_LONG : TREND_TO_SHORT;
        end
        TREND_SHORT: begin
          if (lo < ll) n.factor = boost_factor(s.factor, c);
          n.stop  = trail_stop(s.stop, ll, n.factor);
          n.trend = (n.stop > hi) ? TREND_SHORT : TREND_TO_LONG;
        end
        TREND_TO_SHORT: begin
          n.stop   = hh;
          n.trend  = (hh > hi) ? TREND_SHORT : TREND_TO_LONG;
          n.factor = c.accel_step;
        end
        TREND_TO_LONG: begin
          n.stop   = ll;
          n.trend  = (ll < lo) ? TREND_LONG : TREND_TO_SHORT;
          n.factor = c.accel_step;
        end
        default: ;
      endcase
    end
    return n;
  endfunction

  // checking

  task automatic check_field(input string field, input longint want, input longint got);
    if (want != got) begin
      fail_count++;
      if (fail_count <= 10)
        $display("mismatch on %s: expected %0d, got %0d", field, want, got);
    end
  endtask

  always @(posedge clk_i) begin : observe
    sar_state_t want;
    bar_t       seen;
    bar_note_t  note;
    if (rst_ni) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_START_INDEX: model_cfg.start_index = cfg_ch.data;
          CFG_ACCEL_STEP:  model_cfg.accel_step  = cfg_ch.data;
          CFG_ACCEL_MAX:   model_cfg.accel_max   = cfg_ch.data;
          default: ;
        endcase
      end
      if (res_ch.valid && res_ch.ready) begin
        if (pending_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: trend %0d stop %0d factor %0d",
                     res_ch.trend_state, res_ch.stop_value, res_ch.accel_factor);
        end else begin
          want = pending_results.pop_front();
          check_field("trend_state", longint'(want.trend), longint'(res_ch.trend_state));
          check_field("stop_value", longint'(want.stop), longint'(res_ch.stop_value));
          check_field("accel_factor", longint'(want.factor),
                      longint'(res_ch.accel_factor));
        end
      end
      if (bar_ch.valid && bar_ch.ready) begin
        seen.bar_index      = bar_ch.bar_index;
        seen.bar_high       = bar_ch.bar_high;
        seen.bar_low        = bar_ch.bar_low;
        seen.window_highest = bar_ch.window_highest;
        seen.window_lowest  = bar_ch.window_lowest;
        note = '{pinned: 1'b0, want: '0};
        if (bar_notes.size() > 0) note = bar_notes.pop_front();
        model_state = advance_sar(model_state, seen, model_cfg);
        pending_results.push_back(note.pinned ? note.want : model_state);
      end
    end
  end

  // result receiver
  initial begin
    int n;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req > 0) begin
        n        = hold_req;
        hold_req = 0;
        res_ch.ready <= 1'b0;
        repeat (n) @(negedge clk_i);
      end
      res_ch.ready <= calm || ($urandom_range(99) >= 15);
    end
  end

  // stimulus helpers

  function automatic dir_row_t row_of(input int idx, input int hi, input int lo,
                                      input int hh, input int ll, input bit pinned,
                                      input logic [TREND_W-1:0] tr, input int stop,
                                      input factor_t fac);
    dir_row_t r;
    r.stim.bar_index      = idx[INDEX_W-1:0];
    r.stim.bar_high       = price_t'(hi);
    r.stim.bar_low        = price_t'(lo);
    r.stim.window_highest = price_t'(hh);
    r.stim.window_lowest  = price_t'(ll);
    r.pinned              = pinned;
    r.want.trend          = tr;
    r.want.stop           = price_t'(stop);
    r.want.factor         = fac;
    return r;
  endfunction

  task automatic send_bar(input bar_t b, input bit pinned, input sar_state_t want);
    while (!calm && $urandom_range(99) < 15) begin
      bar_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    bar_notes.push_back('{pinned: pinned, want: want});
    bar_ch.valid          <= 1'b1;
    bar_ch.bar_index      <= b.bar_index;
    bar_ch.bar_high       <= b.bar_high;
    bar_ch.bar_low        <= b.bar_low;
    bar_ch.window_highest <= b.window_highest;
    bar_ch.window_lowest  <= b.window_lowest;
    @(posedge clk_i);
    while (!bar_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FACTOR_W-1:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= v;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    bar_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  function automatic void start_walk(input int unsigned start);
    int unsigned pick;
    phase_start = start;
    bar_pos     = (start > 3) ? start - 3 : 0;
    walk_mid    = longint'($signed($urandom)) >>> 2;
    pick        = $urandom_range(3);
    walk_vol    = (pick == 0) ? (1 << 8) : (pick == 1) ? (1 << 16) :
                  (pick == 2) ? (1 << 22) : (1 << 26);
    window_len  = $urandom_range(1, 8);
    hist_hi.delete();
    hist_lo.delete();
  endfunction

  function automatic bar_t make_bar();
    bar_t b;
    longint hi, lo, hh, ll;
    int unsigned k;
    k = $urandom_range(99);
    if (k < 3) begin
      b.bar_index = INDEX_W'($urandom);
    end else begin
      if (k < 5) bar_pos = phase_start;
      b.bar_index = bar_pos[INDEX_W-1:0];
      if (bar_pos < 65535) bar_pos++;
    end
    if ($urandom_range(99) < 8) begin
      b.bar_high       = $urandom;
      b.bar_low        = $urandom;
      b.window_highest = $urandom;
      b.window_lowest  = $urandom;
      return b;
    end
    walk_mid = clamp_price(walk_mid + longint'($urandom_range(2 * walk_vol))
                           - longint'(walk_vol));
    hi = longint'(clamp_price(walk_mid + longint'($urandom_range(walk_vol))));
    lo = longint'(clamp_price(walk_mid - longint'($urandom_range(walk_vol))));
    hh = hi;
    ll = lo;
    if (hist_hi.size() > 0) begin
      hh = hist_hi[0];
      ll = hist_lo[0];
      foreach (hist_hi[i]) begin
        if (hist_hi[i] > hh) hh = hist_hi[i];
        if (hist_lo[i] < ll) ll = hist_lo[i];
      end
      // sometimes the window also covers the current bar
      if ($urandom_range(9) == 0) begin
        if (hi > hh) hh = hi;
        if (lo < ll) ll = lo;
      end
    end
    hist_hi.push_back(hi);
    hist_lo.push_back(lo);
    if (hist_hi.size() > window_len) begin
      void'(hist_hi.pop_front());
      void'(hist_lo.pop_front());
    end
    b.bar_high       = price_t'(hi);
    b.bar_low        = price_t'(lo);
    b.window_highest = price_t'(hh);
    b.window_lowest  = price_t'(ll);
    return b;
  endfunction

  task automatic run_phase(input logic [INDEX_W-1:0] start, input factor_t step,
                           input factor_t cap, input int n, input phase_kind_e kind);
    drain_results();
    repeat (4) @(negedge clk_i);
    write_reg(CFG_START_INDEX, start);
    write_reg(CFG_ACCEL_STEP, step);
    write_reg(CFG_ACCEL_MAX, cap);
    cfg_ch.valid <= 1'b0;
    start_walk(start);
    calm = (kind == PH_CALM);
    if (kind == PH_BACKPRESSURE) hold_req = 200;
    for (int i = 0; i < n; i++) begin
      if (kind == PH_DRAIN_MIDWAY && i == n / 2) drain_results();
      send_bar(make_bar(), 1'b0, '0);
    end
    calm = 1'b0;
  endtask

  // main sequence
  initial begin
    rst_ni                = 1'b0;
    bar_ch.valid          = 1'b0;
    bar_ch.bar_index      = '0;
    bar_ch.bar_high       = '0;
    bar_ch.bar_low        = '0;
    bar_ch.window_highest = '0;
    bar_ch.window_lowest  = '0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.index          = CFG_START_INDEX;
    cfg_ch.data           = '0;

    // idx, high, low, window high, window low, pinned, trend, stop, factor
    directed_rows.push_back(row_of(0, P_MAX, P_MIN, P_MAX, P_MIN,
                                   1'b1, TREND_NONE, 0, '0));
    directed_rows.push_back(row_of(9, P_MIN, P_MAX, P_MIN, P_MAX,
                                   1'b1, TREND_NONE, 0, '0));
    directed_rows.push_back(row_of(10, 100 * Q1, 90 * Q1, 100 * Q1, 90 * Q1,
                                   1'b1, TREND_NONE, 0, ACCEL_STEP_RST));
    directed_rows.push_back(row_of(11, 50 * Q1, 40 * Q1, 60 * Q1, 30 * Q1,
                                   1'b1, TREND_NONE, 0, ACCEL_STEP_RST));
    directed_rows.push_back(row_of(10, 100 * Q1, 95 * Q1, 100 * Q1, 90 * Q1,
                                   1'b1, TREND_LONG, 90 * Q1, ACCEL_STEP_RST));
    directed_rows.push_back(row_of(11, 105 * Q1, 100 * Q1, 103 * Q1, 92 * Q1,
                                   1'b0, TREND_NONE, 0, '0));
    directed_rows.push_back(row_of(12, 106 * Q1, 101 * Q1, 105 * Q1, 95 * Q1,
                                   1'b0, TREND_NONE, 0, '0));
    directed_rows.push_back(row_of(13, 104 * Q1, 102 * Q1, 106 * Q1, 96 * Q1,
                                   1'b0, TREND_NONE, 0, '0));
    directed_rows.push_back(row_of(14, 104 * Q1, 80 * Q1, 106 * Q1, 80 * Q1,
                                   1'b0, TREND_NONE, 0, '0));
    directed_rows.push_back(row_of(15, 100 * Q1, 78 * Q1, 106 * Q1, 78 * Q1,
                                   1'b1, TREND_SHORT, 106 * Q1, ACCEL_STEP_RST));
    directed_rows.push_back(row_of(16, 99 * Q1, 70 * Q1, 106 * Q1, 75 * Q1,
                                   1'b0, TREND_NONE, 0, '0));
    directed_rows.push_back(row_of(17, 98 * Q1, 72 * Q1, 104 * Q1, 70 * Q1,
                                   1'b0, TREND_NONE, 0, '0));
    directed_rows.push_back(row_of(18, 120 * Q1, 90 * Q1, 120 * Q1, 70 * Q1,
                                   1'b0, TREND_NONE, 0, '0));
    directed_rows.push_back(row_of(19, 125 * Q1, 80 * Q1, 125 * Q1, 85 * Q1,
                                   1'b1, TREND_TO_SHORT, 85 * Q1, ACCEL_STEP_RST));
    directed_rows.push_back(row_of(20, 130 * Q1, 100 * Q1, 128 * Q1, 95 * Q1,
                                   1'b1, TREND_TO_LONG, 128 * Q1, ACCEL_STEP_RST));
    directed_rows.push_back(row_of(21, 130 * Q1, 100 * Q1, 131 * Q1, 95 * Q1,
                                   1'b1, TREND_LONG, 95 * Q1, ACCEL_STEP_RST));
    // both seeding tests hold, short wins
    directed_rows.push_back(row_of(10, 100 * Q1, 95 * Q1, 110 * Q1, 90 * Q1,
                                   1'b1, TREND_SHORT, 110 * Q1, ACCEL_STEP_RST));
    directed_rows.push_back(row_of(10, P_MAX, P_MIN + 1, P_MAX, P_MIN,
                                   1'b1, TREND_LONG, P_MIN, ACCEL_STEP_RST));
    directed_rows.push_back(row_of(65535, P_MAX, P_MAX, P_MAX, P_MIN,
                                   1'b0, TREND_NONE, 0, '0));
    directed_rows.push_back(row_of(65535, P_MAX, P_MIN, P_MAX, P_MIN,
                                   1'b0, TREND_NONE, 0, '0));
    directed_rows.push_back(row_of(12, P_MIN, P_MIN, P_MAX, P_MIN,
                                   1'b1, TREND_SHORT, P_MAX, ACCEL_STEP_RST));
    directed_rows.push_back(row_of(13, P_MIN, P_MIN, P_MAX, P_MIN,
                                   1'b0, TREND_NONE, 0, '0));

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i])
      send_bar(directed_rows[i].stim, directed_rows[i].pinned, directed_rows[i].want);

    start_walk(START_INDEX_RST);
    repeat (200) send_bar(make_bar(), 1'b0, '0);

    run_phase(16'd0, 16'd65535, 16'd65535, 230, PH_PLAIN);
    run_phase(16'd65535, 16'd0, 16'd0, 80, PH_PLAIN);
    run_phase(16'd20, 16'd3277, 16'd32768, 250, PH_BACKPRESSURE);
    run_phase(16'd5, ACCEL_STEP_RST, ACCEL_MAX_RST, 250, PH_CALM);
    run_phase(16'd100, 16'd6554, 16'd1000, 230, PH_DRAIN_MIDWAY);
    run_phase(16'd1, 16'd65535, 16'd0, 200, PH_PLAIN);

    drain_results();
    repeat (8) @(negedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
